// ----- hdl/wsd_pkg.sv -----
// wsd_pkg: shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by websocket_frame_deframer_core.
`default_nettype none

package wsd_pkg;

    // Header / payload parse phases
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT16   = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_EXT64   = 3'd5
    } phase_t;

    // Event codes carried on the result stream
    typedef enum logic [2:0] {
        EV_DATA     = 3'd0,
        EV_END      = 3'd1,
        EV_CLOSE    = 3'd2,
        EV_RSV      = 3'd3,
        EV_UNMASKED = 3'd4,
        EV_TOOLONG  = 3'd5
    } event_t;

    // Opcodes of interest
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;

    // 7-bit length escapes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Header byte counts
    localparam logic [3:0] CNT_EXT16 = 4'd2;
    localparam logic [3:0] CNT_EXT64 = 4'd8;
    localparam logic [3:0] CNT_MASK  = 4'd4;

    localparam logic [31:0] MAX_LEN_RESET = 32'h0040_0000;  // 4 MiB

endpackage

`default_nettype wire

// ----- hdl/websocket_frame_deframer_core.sv -----
// websocket_frame_deframer_core: RFC 6455 client-to-server frame parser and unmasker.
// Depends on wsd_pkg (phase and event types, opcode and length constants).
//
// Usage:
//   Input stream (s_axis_*): one received byte per transfer on s_axis_tdata.
//   Output stream (m_axis_*): at most one event per input byte.
//     m_axis_tdata = unmasked payload byte (zero unless the event is a data byte),
//     m_axis_tuser = event kind (0 data, 1 empty message end, 2 close,
//                    3 reserved bits error, 4 unmasked error, 5 too long),
//     m_axis_tlast = last byte of a message, or an end-of-message marker.
//   Config: cfg_wr_en/cfg_wr_data write the limit on 64-bit extended lengths.
//     Write it only while the block is idle.
// Output: an event is on m_axis in the cycle after the byte that caused it.
// Throughput: one byte per cycle while s_axis_tready is high, as set by the single
//   result register. The parse state updates in the accept cycle; bytes keep flowing
//   while a result waits as long as the output register is being drained or is empty.
// Stall: when m_axis_tready is low and a result is held, s_axis_tready drops.
// Reset: parser returns to the first header byte, limit returns to 4 MiB,
//   output is emptied. After a close or an error the block swallows all input
//   with no further events until the next reset.
`default_nettype none

module websocket_frame_deframer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,    // max_payload_length
    // received bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    // events
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0]       m_axis_tuser,   // [2:0] event_kind
    output logic             m_axis_tlast    // message_end
);
    import wsd_pkg::*;

    // ---------------- state ----------------
    logic [31:0] max_len_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  hdr_cnt_reg, hdr_cnt_next;
    logic        final_reg, final_next;
    logic [63:0] rem_reg, rem_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  mpos_reg, mpos_next;
    logic        in_msg_reg, in_msg_next;
    logic        has_data_reg, has_data_next;
    logic        halted_reg, halted_next;

    // result register
    logic        out_valid_reg;
    logic [2:0]  out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;

    // event from the current byte
    logic        ev_valid;
    event_t      ev_kind;
    logic [7:0]  ev_byte;
    logic        ev_end;

    // ---------------- decode helpers ----------------
    logic        accept;
    logic        step;
    logic [7:0]  b;
    logic [3:0]  op;
    logic        rsv_set;
    logic [6:0]  len7;
    logic [63:0] ext_len;
    logic        cnt_last;
    logic        too_long;
    logic        pay_last;
    logic [7:0]  key_byte;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign step     = accept && !halted_reg;
    assign b        = s_axis_tdata;
    assign op       = b[3:0];
    assign rsv_set  = (b[6:4] != 3'd0);
    assign len7     = b[6:0];
    assign ext_len  = {rem_reg[55:0], b};
    assign cnt_last = (hdr_cnt_reg == 4'd1);
    assign too_long = (phase_reg == PH_EXT64) && cnt_last &&
                      ((ext_len[63:32] != 32'd0) || (ext_len[31:0] > max_len_reg));
    assign pay_last = (rem_reg == 64'd1);

    always_comb
    begin
        case (mpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // ---------------- next phase ----------------
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    if (op != OP_CLOSE && !rsv_set)
                        phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (b[7])
                    begin
                        if (len7 == LEN_EXT16)
                            phase_next = PH_EXT16;
                        else if (len7 == LEN_EXT64)
                            phase_next = PH_EXT64;
                        else
                            phase_next = PH_MASK;
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    if (cnt_last && !too_long)
                        phase_next = PH_MASK;
                end
                PH_MASK:
                begin
                    if (cnt_last)
                        phase_next = (rem_reg != 64'd0) ? PH_PAYLOAD : PH_HDR0;
                end
                PH_PAYLOAD:
                begin
                    if (pay_last)
                        phase_next = PH_HDR0;
                end
                default:
                    phase_next = PH_HDR0;
            endcase
        end
    end

    // ---------------- datapath and events ----------------
    always_comb
    begin
        hdr_cnt_next  = hdr_cnt_reg;
        final_next    = final_reg;
        rem_next      = rem_reg;
        key_next      = key_reg;
        mpos_next     = mpos_reg;
        in_msg_next   = in_msg_reg;
        has_data_next = has_data_reg;
        halted_next   = halted_reg;
        ev_valid      = 1'b0;
        ev_kind       = EV_DATA;
        ev_byte       = 8'd0;
        ev_end        = 1'b0;

        if (step)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    final_next  = b[7];
                    if (op == OP_CLOSE)
                    begin
                        halted_next = 1'b1;
                        ev_valid    = 1'b1;
                        ev_kind     = EV_CLOSE;
                    end
                    else if (rsv_set)
                    begin
                        halted_next = 1'b1;
                        ev_valid    = 1'b1;
                        ev_kind     = EV_RSV;
                    end
                    else if (op == OP_TEXT || op == OP_BINARY)
                    begin
                        // a new message closes out one that already sent bytes
                        in_msg_next   = 1'b1;
                        has_data_next = 1'b0;
                        if (in_msg_reg && has_data_reg)
                        begin
                            ev_valid = 1'b1;
                            ev_kind  = EV_END;
                            ev_end   = 1'b1;
                        end
                    end
                    else if (op != OP_CONT)
                    begin
                        // other non-data opcodes (close aside) end the message silently
                        in_msg_next   = 1'b0;
                        has_data_next = 1'b0;
                    end
                end
                PH_HDR1:
                begin
                    if (!b[7])
                    begin
                        halted_next = 1'b1;
                        ev_valid    = 1'b1;
                        ev_kind     = EV_UNMASKED;
                    end
                    else
                    begin
                        key_next = 32'd0;
                        if (len7 == LEN_EXT16)
                        begin
                            rem_next     = 64'd0;
                            hdr_cnt_next = CNT_EXT16;
                        end
                        else if (len7 == LEN_EXT64)
                        begin
                            rem_next     = 64'd0;
                            hdr_cnt_next = CNT_EXT64;
                        end
                        else
                        begin
                            rem_next     = {57'd0, len7};
                            hdr_cnt_next = CNT_MASK;
                        end
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    rem_next     = ext_len;
                    hdr_cnt_next = hdr_cnt_reg - 4'd1;
                    if (too_long)
                    begin
                        halted_next = 1'b1;
                        ev_valid    = 1'b1;
                        ev_kind     = EV_TOOLONG;
                    end
                    else if (cnt_last)
                        hdr_cnt_next = CNT_MASK;
                end
                PH_MASK:
                begin
                    key_next     = {key_reg[23:0], b};
                    hdr_cnt_next = hdr_cnt_reg - 4'd1;
                    if (cnt_last)
                    begin
                        mpos_next = 2'd0;
                        // empty final frame ends the message
                        if (rem_reg == 64'd0 && in_msg_reg && final_reg)
                        begin
                            in_msg_next   = 1'b0;
                            has_data_next = 1'b0;
                            if (has_data_reg)
                            begin
                                ev_valid = 1'b1;
                                ev_kind  = EV_END;
                                ev_end   = 1'b1;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    rem_next  = rem_reg - 64'd1;
                    mpos_next = mpos_reg + 2'd1;
                    if (in_msg_reg)
                    begin
                        ev_valid      = 1'b1;
                        ev_kind       = EV_DATA;
                        ev_byte       = b ^ key_byte;
                        ev_end        = pay_last && final_reg;
                        has_data_next = 1'b1;
                    end
                    if (pay_last && final_reg && in_msg_reg)
                    begin
                        in_msg_next   = 1'b0;
                        has_data_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= MAX_LEN_RESET;
            phase_reg     <= PH_HDR0;
            hdr_cnt_reg   <= 4'd0;
            final_reg     <= 1'b0;
            rem_reg       <= 64'd0;
            key_reg       <= 32'd0;
            mpos_reg      <= 2'd0;
            in_msg_reg    <= 1'b0;
            has_data_reg  <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                max_len_reg <= cfg_wr_data;
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            final_reg    <= final_next;
            rem_reg      <= rem_next;
            key_reg      <= key_next;
            mpos_reg     <= mpos_next;
            in_msg_reg   <= in_msg_next;
            has_data_reg <= has_data_next;
            halted_reg   <= halted_next;
            if (ev_valid)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded only when a new event is produced
    always_ff @(posedge clk)
    begin
        if (ev_valid)
        begin
            out_kind_reg <= ev_kind;
            out_byte_reg <= ev_byte;
            out_end_reg  <= ev_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_end_reg;

endmodule

`default_nettype wire
